// File: src/open_address_hash_table_defines.svh
// Assertion macros shared by the hash table RTL.
// Used by oaht_mod_unit and open_address_hash_table; expects clk and arst_n in scope.
`ifndef OPEN_ADDRESS_HASH_TABLE_DEFINES_SVH
`define OPEN_ADDRESS_HASH_TABLE_DEFINES_SVH

// Checked outside reset only
`define OAHT_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked at every edge, reset included
`define OAHT_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: src/oaht_pkg.sv
// Shared constants, codes and interface structs of the hash table.
// No dependencies; imported by every module of the block.
package oaht_pkg;

	localparam int CAPACITY = 64;
	localparam int SLOT_W   = $clog2(CAPACITY);
	localparam int COUNT_W  = $clog2(CAPACITY + 1);
	localparam int KEY_W    = 32;
	localparam int SIZE_W   = 7;
	localparam int OFF_W    = 6;
	localparam int NBITS_W  = $clog2(KEY_W + 1);

	// Operation codes
	localparam logic [1:0] OP_INSERT = 2'd0;
	localparam logic [1:0] OP_FIND   = 2'd1;
	localparam logic [1:0] OP_REMOVE = 2'd2;
	localparam logic [1:0] OP_LOAD   = 2'd3;

	// Status codes
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [1:0] ST_FULL      = 2'd2;
	localparam logic [1:0] ST_PRESENT   = 2'd3;

	// Request to the shared modulo unit
	typedef struct packed {
		logic               start;
		logic               neg;
		logic [NBITS_W-1:0] nbits;
		logic [KEY_W-1:0]   dividend;
		logic [SIZE_W-1:0]  divisor;
	} mod_req_t;

	typedef struct packed {
		logic              done;
		logic [SLOT_W-1:0] rem;
	} mod_rsp_t;

	// Store control: slot write, slot read, offset write and offset read
	typedef struct packed {
		logic              slot_we;
		logic [SLOT_W-1:0] slot_waddr;
		logic [KEY_W-1:0]  wr_key;
		logic [KEY_W-1:0]  wr_elem;
		logic [SLOT_W-1:0] slot_raddr;
		logic              off_we;
		logic [SLOT_W-1:0] off_waddr;
		logic [OFF_W-1:0]  off_wdata;
		logic [SLOT_W-1:0] off_raddr;
	} st_req_t;

endpackage

// File: src/oaht_mod_unit.sv
// Shared bit-serial modulo unit: restoring remainder, one dividend bit per cycle.
// Depends on oaht_pkg and open_address_hash_table_defines.svh.
`include "open_address_hash_table_defines.svh"

module oaht_mod_unit
	import oaht_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  mod_req_t req,
	output mod_rsp_t rsp
);

	logic [KEY_W-1:0]   dvd_q;
	logic [SIZE_W-1:0]  rem_q;
	logic [SIZE_W-1:0]  divisor_q;
	logic [NBITS_W-1:0] cnt_q;
	logic               neg_q;
	logic               busy_q;
	logic               done_q;

	logic [SIZE_W-1:0] shifted;
	logic [SIZE_W-1:0] diff;

	// One remainder step: shift in the next dividend bit, subtract if it fits
	assign shifted = {rem_q[SIZE_W-2:0], dvd_q[KEY_W-1]};
	assign diff    = shifted - divisor_q;

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= req.nbits;
			end else if (busy_q) begin
				if (cnt_q != '0) begin
					cnt_q <= cnt_q - 1'b1;
				end else begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath; the last cycle folds a negative dividend into [0, divisor)
	always_ff @(posedge clk) begin
		if (req.start) begin
			dvd_q     <= req.dividend;
			divisor_q <= req.divisor;
			neg_q     <= req.neg;
			rem_q     <= '0;
		end else if (busy_q) begin
			if (cnt_q != '0) begin
				dvd_q <= {dvd_q[KEY_W-2:0], 1'b0};
				rem_q <= (shifted >= divisor_q) ? diff : shifted;
			end else if (neg_q && rem_q != '0) begin
				rem_q <= divisor_q - rem_q;
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.rem  = rem_q[SLOT_W-1:0];

	`OAHT_ASSERT(a_rem_in_range, done_q |-> (rem_q < divisor_q), "remainder not below divisor")
	`OAHT_ASSERT(a_start_busy, req.start |=> busy_q, "start did not launch the unit")
	`OAHT_ASSERT_ALWAYS(a_done_idle, done_q |-> !busy_q, "done raised while busy")

endmodule

// File: src/oaht_store.sv
// Slot key, slot element and probe offset memories with registered reads.
// Depends on oaht_pkg.
module oaht_store
	import oaht_pkg::*;
(
	input  logic             clk,
	input  st_req_t          req,
	output logic [KEY_W-1:0] rd_key,
	output logic [KEY_W-1:0] rd_elem,
	output logic [OFF_W-1:0] rd_off
);

	logic [KEY_W-1:0] key_mem  [CAPACITY];
	logic [KEY_W-1:0] elem_mem [CAPACITY];
	logic [OFF_W-1:0] off_mem  [CAPACITY];

	logic [KEY_W-1:0] rd_key_q;
	logic [KEY_W-1:0] rd_elem_q;
	logic [OFF_W-1:0] rd_off_q;

	// Slot memories: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (req.slot_we) begin
			key_mem[req.slot_waddr]  <= req.wr_key;
			elem_mem[req.slot_waddr] <= req.wr_elem;
		end
		rd_key_q  <= key_mem[req.slot_raddr];
		rd_elem_q <= elem_mem[req.slot_raddr];
	end

	// Probe offset memory
	always_ff @(posedge clk) begin
		if (req.off_we) begin
			off_mem[req.off_waddr] <= req.off_wdata;
		end
		rd_off_q <= off_mem[req.off_raddr];
	end

	assign rd_key  = rd_key_q;
	assign rd_elem = rd_elem_q;
	assign rd_off  = rd_off_q;

endmodule

// File: src/open_address_hash_table.sv
// Top level of the open-addressing hash table: sequencer, slot full bits, output register.
// Depends on oaht_pkg, oaht_mod_unit, oaht_store and open_address_hash_table_defines.svh.
//
// One transaction at a time. Insert, find and remove first reduce the key modulo the table
// size in the shared bit-serial modulo unit (32 steps), then walk the probe path one step
// at a time: every further step reads its offset, reduces home + offset through the same
// unit (7 steps) and reads the slot. Insert adds a write state after the walk.
// in_ready is high whenever the sequencer is idle, also while a result waits in the output
// register. table_size is written through cfg_we / cfg_wdata; the user must write it only
// while no transaction is open, as the block itself does not enforce this.
`include "open_address_hash_table_defines.svh"

module open_address_hash_table
	import oaht_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [SIZE_W-1:0]        cfg_wdata,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [1:0]               op,
	input  logic signed [KEY_W-1:0]  key,
	input  logic signed [KEY_W-1:0]  value,
	input  logic [OFF_W-1:0]         offset_index,
	input  logic [OFF_W-1:0]         offset_value,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [1:0]               status,
	output logic signed [KEY_W-1:0]  found_value,
	output logic [SLOT_W-1:0]        slot_used
);

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_HSTART = 4'd1;
	localparam logic [3:0] S_HOME   = 4'd2;
	localparam logic [3:0] S_OFFRD  = 4'd3;
	localparam logic [3:0] S_PSTART = 4'd4;
	localparam logic [3:0] S_PMOD   = 4'd5;
	localparam logic [3:0] S_KEYRD  = 4'd6;
	localparam logic [3:0] S_CMP    = 4'd7;
	localparam logic [3:0] S_WRITE  = 4'd8;
	localparam logic [3:0] S_OLOAD  = 4'd9;
	localparam logic [3:0] S_DONE   = 4'd10;

	logic [3:0]          state_q;
	logic [SIZE_W-1:0]   table_size_q;
	logic [COUNT_W-1:0]  entry_count_q;
	logic [CAPACITY-1:0] slot_full_q;

	logic [1:0]          op_q;
	logic [KEY_W-1:0]    key_q;
	logic [KEY_W-1:0]    value_q;
	logic [OFF_W-1:0]    oidx_q;
	logic [OFF_W-1:0]    oval_q;
	logic [SIZE_W-1:0]   size_q;
	logic [SLOT_W-1:0]   home_q;
	logic [SLOT_W-1:0]   slot_q;
	logic [SIZE_W-1:0]   j_q;
	logic [SLOT_W-1:0]   first_free_q;
	logic                have_free_q;

	logic [1:0]          res_status_q;
	logic [KEY_W-1:0]    res_found_q;
	logic [SLOT_W-1:0]   res_slot_q;

	logic                out_valid_q;
	logic [1:0]          status_q;
	logic [KEY_W-1:0]    found_q;
	logic [SLOT_W-1:0]   slot_used_q;

	logic [SIZE_W-1:0]   eff_size;
	logic                accept;
	logic                match;
	logic                slot_free;
	logic                last_step;
	logic                nxt_have_free;
	logic [SLOT_W-1:0]   nxt_first_free;
	logic [SIZE_W-1:0]   probe_sum;
	logic [KEY_W-1:0]    key_mag;

	mod_req_t            mod_req;
	mod_rsp_t            mod_rsp;
	st_req_t             st_req;
	logic [KEY_W-1:0]    rd_key;
	logic [KEY_W-1:0]    rd_elem;
	logic [OFF_W-1:0]    rd_off;

	// Size register clamped to [2, CAPACITY]
	always_comb begin
		if (table_size_q < SIZE_W'(2)) begin
			eff_size = SIZE_W'(2);
		end else if (table_size_q > SIZE_W'(CAPACITY)) begin
			eff_size = SIZE_W'(CAPACITY);
		end else begin
			eff_size = table_size_q;
		end
	end

	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;

	// Probe step evaluation
	assign match          = slot_full_q[slot_q] && (rd_key == key_q);
	assign slot_free      = !slot_full_q[slot_q];
	assign last_step      = ((j_q + 1'b1) == size_q);
	assign nxt_have_free  = have_free_q || slot_free;
	assign nxt_first_free = have_free_q ? first_free_q : slot_q;
	assign probe_sum      = {1'b0, home_q} + {1'b0, rd_off};
	assign key_mag        = key_q[KEY_W-1] ? (~key_q + 1'b1) : key_q;

	// Shared modulo unit: home slot from the key, probe slot from home + offset
	always_comb begin
		mod_req.start    = (state_q == S_HSTART) || (state_q == S_PSTART);
		mod_req.divisor  = size_q;
		if (state_q == S_HSTART) begin
			mod_req.neg      = key_q[KEY_W-1];
			mod_req.nbits    = NBITS_W'(KEY_W);
			mod_req.dividend = key_mag;
		end else begin
			mod_req.neg      = 1'b0;
			mod_req.nbits    = NBITS_W'(SIZE_W);
			mod_req.dividend = {probe_sum, {(KEY_W - SIZE_W){1'b0}}};
		end
	end

	oaht_mod_unit u_mod (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mod_req),
		.rsp    (mod_rsp)
	);

	// Store accesses
	always_comb begin
		st_req.slot_we    = (state_q == S_WRITE);
		st_req.slot_waddr = first_free_q;
		st_req.wr_key     = key_q;
		st_req.wr_elem    = value_q;
		st_req.slot_raddr = slot_q;
		st_req.off_we     = (state_q == S_OLOAD) && (oidx_q != '0);
		st_req.off_waddr  = oidx_q;
		st_req.off_wdata  = oval_q;
		st_req.off_raddr  = j_q[SLOT_W-1:0];
	end

	oaht_store u_store (
		.clk     (clk),
		.req     (st_req),
		.rd_key  (rd_key),
		.rd_elem (rd_elem),
		.rd_off  (rd_off)
	);

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			table_size_q <= SIZE_W'(CAPACITY);
		end else if (cfg_we) begin
			table_size_q <= cfg_wdata;
		end
	end

	// Sequencer and table state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			entry_count_q <= '0;
			slot_full_q   <= '0;
			have_free_q   <= 1'b0;
			j_q           <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (op == OP_LOAD) begin
							state_q <= S_OLOAD;
						end else if (op == OP_INSERT &&
							SIZE_W'(entry_count_q) >= eff_size) begin
							state_q <= S_DONE;
						end else begin
							state_q <= S_HSTART;
						end
					end
				end
				S_HSTART: state_q <= S_HOME;
				S_HOME: begin
					if (mod_rsp.done) begin
						j_q         <= '0;
						have_free_q <= 1'b0;
						state_q     <= S_KEYRD;
					end
				end
				S_OFFRD:  state_q <= S_PSTART;
				S_PSTART: state_q <= S_PMOD;
				S_PMOD: begin
					if (mod_rsp.done) begin
						state_q <= S_KEYRD;
					end
				end
				S_KEYRD: state_q <= S_CMP;
				S_CMP: begin
					if (match) begin
						if (op_q == OP_REMOVE) begin
							slot_full_q[slot_q] <= 1'b0;
							if (entry_count_q != '0) begin
								entry_count_q <= entry_count_q - 1'b1;
							end
						end
						state_q <= S_DONE;
					end else begin
						have_free_q <= nxt_have_free;
						if (last_step) begin
							if (op_q == OP_INSERT && nxt_have_free) begin
								state_q <= S_WRITE;
							end else begin
								state_q <= S_DONE;
							end
						end else begin
							j_q     <= j_q + 1'b1;
							state_q <= S_OFFRD;
						end
					end
				end
				S_WRITE: begin
					slot_full_q[first_free_q] <= 1'b1;
					entry_count_q             <= entry_count_q + 1'b1;
					state_q                   <= S_DONE;
				end
				S_OLOAD: state_q <= S_DONE;
				S_DONE: begin
					if (!out_valid_q || out_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Transaction payload, probe slots and pending result
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					op_q         <= op;
					key_q        <= key;
					value_q      <= value;
					oidx_q       <= offset_index;
					oval_q       <= offset_value;
					size_q       <= eff_size;
					res_status_q <= ST_FULL;
					res_found_q  <= '0;
					res_slot_q   <= '0;
				end
			end
			S_HOME: begin
				if (mod_rsp.done) begin
					home_q <= mod_rsp.rem;
					slot_q <= mod_rsp.rem;
				end
			end
			S_PMOD: begin
				if (mod_rsp.done) begin
					slot_q <= mod_rsp.rem;
				end
			end
			S_CMP: begin
				first_free_q <= nxt_first_free;
				if (match) begin
					if (op_q == OP_INSERT) begin
						res_status_q <= ST_PRESENT;
					end else begin
						res_status_q <= ST_OK;
						res_slot_q   <= slot_q;
						if (op_q == OP_FIND) begin
							res_found_q <= rd_elem;
						end
					end
				end else if (last_step) begin
					res_status_q <= (op_q == OP_INSERT) ? ST_FULL : ST_NOT_FOUND;
				end
			end
			S_WRITE: begin
				res_status_q <= ST_OK;
				res_slot_q   <= first_free_q;
			end
			S_OLOAD: begin
				res_status_q <= ST_OK;
			end
			default: ;
		endcase
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_DONE && (!out_valid_q || out_ready)) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DONE && (!out_valid_q || out_ready)) begin
			status_q    <= res_status_q;
			found_q     <= res_found_q;
			slot_used_q <= res_slot_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign found_value = found_q;
	assign slot_used   = slot_used_q;

	`OAHT_ASSERT_ALWAYS(a_count_tracks_full, ($countones(slot_full_q) == entry_count_q), "entry count out of step with full bits")
	`OAHT_ASSERT(a_write_free_slot, (state_q == S_WRITE) |-> !slot_full_q[first_free_q], "insert into a full slot")
	`OAHT_ASSERT(a_busy_after_accept, (in_valid && in_ready) |=> !in_ready, "ready held after accept")

endmodule
